// File: rtl/core/chse_pkg.sv
// ---------------------------------------------------------------------------
// chse_pkg
// Shared types and constants for the cuckoo hash set engine.
// ---------------------------------------------------------------------------
`default_nettype none
package chse_pkg;

   localparam int unsigned SLOTS_DEF    = 1024;
   localparam int unsigned KEY_BITS_DEF = 32;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned NSLOT_W      = 11;
   localparam int unsigned ROUNDS_W     = 8;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED0  = 2'd0,
      CSR_SEED1  = 2'd1,
      CSR_NSLOTS = 2'd2,
      CSR_ROUNDS = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_HASH,
      ST_MOD,
      ST_READ,
      ST_CHECK,
      ST_INS0_MOD,
      ST_INS0_RD,
      ST_INS0_WR,
      ST_INS1_MOD,
      ST_INS1_RD,
      ST_INS1_WR,
      ST_DONE
   } state_type;

   // request/reply between sequencer and the shared modulo unit
   typedef struct packed {
      logic start;
   } mod_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_sts_type;

endpackage : chse_pkg
`default_nettype wire

// File: rtl/core/chse_mod_unit.sv
// ---------------------------------------------------------------------------
// chse_mod_unit
// Shared restoring remainder unit: one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module chse_mod_unit #(
   parameter int unsigned KEY_BITS = chse_pkg::KEY_BITS_DEF,
   parameter int unsigned DIV_W    = 21
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire chse_pkg::mod_ctl_type   ctl,
   input  wire logic [KEY_BITS-1:0]     dividend,
   input  wire logic [DIV_W-1:0]        divisor,
   output chse_pkg::mod_sts_type        sts,
   output logic [DIV_W-1:0]             remainder
);
   localparam int unsigned CNT_W = $clog2(KEY_BITS + 1);

   logic [KEY_BITS-1:0] shf_ff, shf_in;
   logic [DIV_W:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIV_W:0]      trial;

   always_comb begin
      shf_in  = shf_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DIV_W-1:0], shf_ff[KEY_BITS-1]};
      if (ctl.start) begin
         shf_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(KEY_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         shf_in = shf_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shf_ff <= shf_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff[DIV_W-1:0];
endmodule : chse_mod_unit
`default_nettype wire

// File: rtl/core/chse_table.sv
// ---------------------------------------------------------------------------
// chse_table
// One key table: key memory plus valid memory, one port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module chse_table #(
   parameter int unsigned SLOTS    = chse_pkg::SLOTS_DEF,
   parameter int unsigned KEY_BITS = chse_pkg::KEY_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic [$clog2(SLOTS)-1:0]  addr,
   input  wire logic                      wr_key,
   input  wire logic [KEY_BITS-1:0]       wkey,
   input  wire logic                      wr_vld,
   input  wire logic                      wvld,
   output logic [KEY_BITS-1:0]            rkey,
   output logic                           rvld
);
   logic [KEY_BITS-1:0] keys [SLOTS];
   logic                vlds [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_key) begin
         keys[addr] <= wkey;
      end
      rkey <= keys[addr];
   end

   always_ff @(posedge clock) begin
      if (wr_vld) begin
         vlds[addr] <= wvld;
      end
      rvld <= vlds[addr];
   end
endmodule : chse_table
`default_nettype wire

// File: rtl/core/cuckoo_hash_set_engine.sv
// ---------------------------------------------------------------------------
// cuckoo_hash_set_engine
// Two-table cuckoo hash set of keys: lookup, insert with displacement, remove.
// ---------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata: opcode[1:0], key
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: success, placement_failed,
//          |     |                        |        stranded_key
//  csr     | in  | csr_wr_en              | csr_index, csr_wdata
//
// After reset a clearing pass walks all SLOTS rows of both valid memories,
// with req_tready low. Lookup/remove: two slot indices from the shared
// remainder unit, one after the other, then read, check and load the result.
// Insert then runs displacement rounds, each computing a table 0 slot and a
// table 1 slot; the first round skips the table 0 remainder as its slot is
// known. One beat in flight; the result sits in an output register and
// a new beat is taken the cycle after it has been collected.
`default_nettype none
module cuckoo_hash_set_engine #(
   parameter int unsigned SLOTS    = chse_pkg::SLOTS_DEF,
   parameter int unsigned KEY_BITS = chse_pkg::KEY_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // {key, opcode} from bit 0 up, zero filled to bytes
   input  wire logic [((KEY_BITS+2+7)/8)*8-1:0] req_tdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // {stranded_key, placement_failed, success} from bit 0 up
   output logic [((KEY_BITS+2+7)/8)*8-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic                          csr_wr_en,
   input  wire logic [chse_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [chse_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int unsigned AW     = $clog2(SLOTS);
   localparam int unsigned DIV_W  = AW + 1;
   localparam int unsigned TD_W   = ((KEY_BITS + 2 + 7) / 8) * 8;
   localparam int unsigned SEED_W = (KEY_BITS < 32) ? KEY_BITS : 32;

   // ---- configuration ----
   logic [31:0]                     seed0_ff, seed1_ff;
   logic [chse_pkg::NSLOT_W-1:0]    nslots_ff;
   logic [chse_pkg::ROUNDS_W-1:0]   rounds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed0_ff  <= 32'd0;
         seed1_ff  <= 32'd1;
         nslots_ff <= chse_pkg::NSLOT_W'(1024);
         rounds_ff <= chse_pkg::ROUNDS_W'(100);
      end else if (csr_wr_en) begin
         unique case (chse_pkg::csr_idx_type'(csr_index))
            chse_pkg::CSR_SEED0:  seed0_ff  <= csr_wdata;
            chse_pkg::CSR_SEED1:  seed1_ff  <= csr_wdata;
            chse_pkg::CSR_NSLOTS: nslots_ff <= csr_wdata[chse_pkg::NSLOT_W-1:0];
            chse_pkg::CSR_ROUNDS: rounds_ff <= csr_wdata[chse_pkg::ROUNDS_W-1:0];
            default: ;
         endcase
      end
   end

   // effective modulus: 0 -> 1, above SLOTS -> SLOTS
   logic [DIV_W-1:0] modn;
   always_comb begin
      if (nslots_ff == '0) begin
         modn = DIV_W'(1);
      end else if ({21'd0, nslots_ff} > 32'(SLOTS)) begin
         modn = DIV_W'(SLOTS);
      end else begin
         modn = DIV_W'({21'd0, nslots_ff});
      end
   end

   logic [KEY_BITS-1:0] seed0_k, seed1_k;
   assign seed0_k = KEY_BITS'(seed0_ff[SEED_W-1:0]);
   assign seed1_k = KEY_BITS'(seed1_ff[SEED_W-1:0]);

   // ---- working registers ----
   chse_pkg::state_type state_ff, state_in;
   chse_pkg::op_type    op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;      // input key
   logic [KEY_BITS-1:0] carry_ff, carry_in;  // key being placed
   logic [AW-1:0]       ia_ff, ia_in, ib_ff, ib_in;
   logic                hsel_ff, hsel_in;    // which seed the divider runs
   logic [chse_pkg::ROUNDS_W-1:0] rnd_ff, rnd_in;
   logic [AW:0]         clr_ff, clr_in;
   logic                rv_ff, rv_in;
   logic                ok_ff, ok_in, fail_ff, fail_in;
   logic [KEY_BITS-1:0] strand_ff, strand_in;

   // ---- shared remainder unit ----
   chse_pkg::mod_ctl_type mctl;
   chse_pkg::mod_sts_type msts;
   logic [KEY_BITS-1:0]   mdiv;
   logic [DIV_W-1:0]      mrem;

   chse_mod_unit #(.KEY_BITS(KEY_BITS), .DIV_W(DIV_W)) u_mod (
      .clock, .reset, .ctl(mctl), .dividend(mdiv), .divisor(modn),
      .sts(msts), .remainder(mrem)
   );

   // ---- tables ----
   logic [AW-1:0]       a0, a1;
   logic                wk0, wk1, wv0, wv1, vv0, vv1;
   logic [KEY_BITS-1:0] wkey, rk0, rk1;
   logic                rv0, rv1;

   chse_table #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_t0 (
      .clock, .addr(a0), .wr_key(wk0), .wkey, .wr_vld(wv0), .wvld(vv0),
      .rkey(rk0), .rvld(rv0)
   );
   chse_table #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_t1 (
      .clock, .addr(a1), .wr_key(wk1), .wkey, .wr_vld(wv1), .wvld(vv1),
      .rkey(rk1), .rvld(rv1)
   );

   logic hit0, hit1;
   assign hit0 = rv0 && (rk0 == key_ff);
   assign hit1 = rv1 && (rk1 == key_ff);
   logic [AW-1:0] mrem_a;
   assign mrem_a = mrem[AW-1:0];

   // ---- sequencer ----
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      carry_in  = carry_ff;
      ia_in     = ia_ff;
      ib_in     = ib_ff;
      hsel_in   = hsel_ff;
      rnd_in    = rnd_ff;
      clr_in    = clr_ff;
      rv_in     = rv_ff;
      ok_in     = ok_ff;
      fail_in   = fail_ff;
      strand_in = strand_ff;
      mctl.start = 1'b0;
      mdiv      = carry_ff ^ (hsel_ff ? seed1_k : seed0_k);
      a0 = ia_ff;  a1 = ib_ff;
      wk0 = 1'b0; wk1 = 1'b0; wv0 = 1'b0; wv1 = 1'b0;
      vv0 = 1'b0; vv1 = 1'b0;
      wkey = carry_ff;
      req_tready = 1'b0;

      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         chse_pkg::ST_CLEAR: begin
            a0 = clr_ff[AW-1:0];  a1 = clr_ff[AW-1:0];
            wv0 = 1'b1; wv1 = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(SLOTS - 1)) begin
               state_in = chse_pkg::ST_IDLE;
            end
         end
         chse_pkg::ST_IDLE: begin
            req_tready = !rv_ff;
            if (req_tvalid && !rv_ff) begin
               op_in    = chse_pkg::op_type'(req_tdata[1:0]);
               key_in   = req_tdata[KEY_BITS+1:2];
               carry_in = req_tdata[KEY_BITS+1:2];
               hsel_in  = 1'b0;
               ok_in = 1'b0; fail_in = 1'b0; strand_in = '0;
               state_in = chse_pkg::ST_HASH;
            end
         end
         chse_pkg::ST_HASH: begin
            if (op_ff == chse_pkg::OP_NONE) begin
               state_in = chse_pkg::ST_DONE;
            end else begin
               mctl.start = 1'b1;
               state_in = chse_pkg::ST_MOD;
            end
         end
         chse_pkg::ST_MOD: begin
            if (msts.done) begin
               if (!hsel_ff) begin
                  ia_in = mrem_a;  hsel_in = 1'b1;
                  state_in = chse_pkg::ST_HASH;
               end else begin
                  ib_in = mrem_a;  hsel_in = 1'b0;
                  state_in = chse_pkg::ST_READ;
               end
            end
         end
         chse_pkg::ST_READ: state_in = chse_pkg::ST_CHECK;
         chse_pkg::ST_CHECK: begin
            state_in = chse_pkg::ST_DONE;
            unique case (op_ff)
               chse_pkg::OP_LOOKUP: ok_in = hit0 || hit1;
               chse_pkg::OP_REMOVE: begin
                  ok_in = hit0 || hit1;
                  wv0 = hit0;
                  wv1 = !hit0 && hit1;
               end
               chse_pkg::OP_INSERT: begin
                  if (!(hit0 || hit1)) begin
                     rnd_in = '0;
                     if (rounds_ff == '0) begin
                        fail_in = 1'b1;  strand_in = key_ff;
                     end else begin
                        // first index of table 0 is already known
                        state_in = chse_pkg::ST_INS0_RD;
                     end
                  end
               end
               default: ;
            endcase
         end
         chse_pkg::ST_INS0_MOD: begin
            if (msts.done) begin
               ia_in = mrem_a;
               state_in = chse_pkg::ST_INS0_RD;
            end
         end
         chse_pkg::ST_INS0_RD: state_in = chse_pkg::ST_INS0_WR;
         chse_pkg::ST_INS0_WR: begin
            wk0 = 1'b1;  wv0 = 1'b1;  vv0 = 1'b1;
            if (!rv0) begin
               ok_in = 1'b1;
               state_in = chse_pkg::ST_DONE;
            end else begin
               carry_in = rk0;
               hsel_in = 1'b1;
               state_in = chse_pkg::ST_INS1_MOD;
            end
         end
         chse_pkg::ST_INS1_MOD: begin
            mctl.start = !msts.busy && !msts.done;
            if (msts.done) begin
               ib_in = mrem_a;
               state_in = chse_pkg::ST_INS1_RD;
            end
         end
         chse_pkg::ST_INS1_RD: state_in = chse_pkg::ST_INS1_WR;
         chse_pkg::ST_INS1_WR: begin
            wk1 = 1'b1;  wv1 = 1'b1;  vv1 = 1'b1;
            if (!rv1) begin
               ok_in = 1'b1;
               state_in = chse_pkg::ST_DONE;
            end else begin
               carry_in = rk1;
               rnd_in = rnd_ff + 1'b1;
               if (rnd_ff + 1'b1 == rounds_ff) begin
                  fail_in = 1'b1;  strand_in = rk1;
                  state_in = chse_pkg::ST_DONE;
               end else begin
                  hsel_in = 1'b0;
                  state_in = chse_pkg::ST_INS0_MOD;
               end
            end
         end
         chse_pkg::ST_DONE: begin
            rv_in = 1'b1;
            state_in = chse_pkg::ST_IDLE;
         end
         default: state_in = chse_pkg::ST_IDLE;
      endcase

      // remainder unit for table 0 during insert is started on entry
      if (state_ff == chse_pkg::ST_INS0_MOD && !msts.busy && !msts.done) begin
         mctl.start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      carry_ff  <= carry_in;
      ia_ff     <= ia_in;
      ib_ff     <= ib_in;
      rnd_ff    <= rnd_in;
      ok_ff     <= ok_in;
      fail_ff   <= fail_in;
      strand_ff <= strand_in;
      if (reset) begin
         state_ff <= chse_pkg::ST_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
         hsel_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         hsel_ff  <= hsel_in;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = TD_W'({strand_ff, fail_ff, ok_ff});
endmodule : cuckoo_hash_set_engine
`default_nettype wire

// File: rtl/core/chse_checker.sv
// ---------------------------------------------------------------------------
// chse_checker
// Port-level checks of the hash set engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module chse_checker #(
   parameter int unsigned TD_W = 40
) (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_tvalid,
   input wire logic            req_tready,
   input wire logic [TD_W-1:0] rsp_tdata,
   input wire logic            rsp_tvalid,
   input wire logic            rsp_tready
);
   // one beat in flight: no intake while a result waits
   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("intake while result pending");

   a_accept_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid) else $error("result too early");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1])) else $error("ok and failed");

   a_strand_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[1]) |-> (rsp_tdata[TD_W-1:2] == '0))
      else $error("stranded key without failure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
endmodule : chse_checker

bind cuckoo_hash_set_engine chse_checker #(.TD_W(TD_W)) u_chse_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tdata, .rsp_tvalid, .rsp_tready
);
`default_nettype wire
